// File: hw/rtl/mau_pkg.sv
// ----------------------------------------------------------------------------
// mau_pkg
// Shared types, codes and defaults for the modular arithmetic unit.
// ----------------------------------------------------------------------------
package mau_pkg;

  localparam int MOD_BITS_DEF = 31;
  localparam int OPD_W        = 31;
  localparam int WIDE_W       = 64;

  // register byte address
  localparam logic [2:0] MODULUS_ADDR = 3'd0;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_NEG = 3'd2,
    OP_MUL = 3'd3,
    OP_POW = 3'd4,
    OP_INV = 3'd5,
    OP_DIV = 3'd6,
    OP_RED = 3'd7
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOINV  = 2'd1,
    ST_NEGEXP = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]              opcode;
    logic [OPD_W-1:0]        operand_a;
    logic [OPD_W-1:0]        operand_b;
    logic signed [WIDE_W-1:0] wide_operand;
  } in_item_t;

  typedef struct packed {
    logic [OPD_W-1:0] result;
    logic [1:0]       status;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_GO,
    S_MUL_WAIT,
    S_INV_GO,
    S_INV_WAIT,
    S_RED,
    S_DONE
  } seq_state_t;

  typedef enum logic [1:0] {
    E_IDLE,
    E_DIV,
    E_SWAP,
    E_FIN
  } euc_state_t;

  // handshake between sequencer and a serial unit
  typedef struct packed {
    logic start;
  } unit_req_t;

  typedef struct packed {
    logic done;
    logic ok;
  } unit_rsp_t;

endpackage

// File: hw/rtl/modular_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// modular_arithmetic_unit
// Modular add, sub, neg, mul, pow, inverse, divide and wide reduction over
// a programmable modulus, built from bit-serial units.
// ----------------------------------------------------------------------------
//  channel  | signals                               | beat
//  ---------+---------------------------------------+--------------------------
//  in       | in_valid, in_stall, in_data           | one operation
//  out      | out_valid, out_stall, out_data        | result and status
//  cfg      | psel penable pwrite paddr pwdata ...  | modulus, address 0
//
//  Add, sub, neg and range errors finish without a serial unit. Mul: one serial multiply.
//  Pow: one multiply step per exponent bit, both serial multipliers working together.
//  Inv: one shift-subtract division per Euclid step; div adds one multiply.
//  Reduce: takes the 64-bit wide operand one bit a cycle.
//  Reset gives modulus 1. in_stall is high while an item is in flight.
module modular_arithmetic_unit import mau_pkg::*; #(
  parameter int MOD_BITS = MOD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int W   = MOD_BITS;
  localparam int RCW = $clog2(WIDE_W + 1);

  seq_state_t state, state_next;

  logic [W-1:0]       modulus;
  logic [W-1:0]       ra, rb, res;
  logic [1:0]         st;
  logic [2:0]         op;
  logic [WIDE_W-1:0]  n;
  logic               neg;
  logic [RCW-1:0]     rcnt;
  logic               accept;
  logic               a_ok, b_ok;
  logic [W-1:0]       a_w, b_w;
  logic [W:0]         add_s, sub_s, red_d;
  logic [W-1:0]       add_r, sub_r, red_r;
  logic [WIDE_W-1:0]  wabs;
  logic               out_free;

  unit_req_t          mul_req, euc_req;
  unit_rsp_t          mul0_rsp, mul1_rsp, euc_rsp;
  logic [W-1:0]       p0, p1, inv_v;
  logic [W-1:0]       m0_a, m0_b, euc_a;

  // ---------------- configuration
  assign pready = 1'b1;
  assign prdata = 32'(modulus);

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= W'(1);
    end else if (psel && penable && pwrite && paddr == MODULUS_ADDR
                 && pwdata[W-1:0] != '0) begin
      modulus <= pwdata[W-1:0];
    end
  end

  // ---------------- serial units
  assign m0_a  = ra;
  assign m0_b  = rb;
  assign euc_a = (op == OP_DIV) ? rb : ra;

  mau_mulmod #(.W(W)) u_mul0 (
    .clk(clk), .rst(rst), .req(mul_req), .a(m0_a), .b(m0_b), .m(modulus),
    .rsp(mul0_rsp), .p(p0)
  );

  mau_mulmod #(.W(W)) u_mul1 (
    .clk(clk), .rst(rst), .req(mul_req), .a(rb), .b(rb), .m(modulus),
    .rsp(mul1_rsp), .p(p1)
  );

  mau_euclid #(.W(W)) u_euc (
    .clk(clk), .rst(rst), .req(euc_req), .a(euc_a), .m(modulus),
    .rsp(euc_rsp), .inv(inv_v)
  );

  // ---------------- simple operations
  assign a_ok  = in_data.operand_a < OPD_W'(modulus);
  assign b_ok  = in_data.operand_b < OPD_W'(modulus);
  assign a_w   = in_data.operand_a[W-1:0];
  assign b_w   = in_data.operand_b[W-1:0];
  assign add_s = {1'b0, a_w} + {1'b0, b_w};
  assign add_r = (add_s >= {1'b0, modulus}) ? W'(add_s - {1'b0, modulus}) : add_s[W-1:0];
  assign sub_s = {1'b0, a_w} + {1'b0, modulus} - {1'b0, b_w};
  assign sub_r = (a_w >= b_w) ? (a_w - b_w) : sub_s[W-1:0];
  assign wabs  = in_data.wide_operand[WIDE_W-1] ? (~in_data.wide_operand + 1'b1)
                                                : in_data.wide_operand;

  assign red_d = {ra, n[WIDE_W-1]};
  assign red_r = (red_d >= {1'b0, modulus}) ? W'(red_d - {1'b0, modulus}) : red_d[W-1:0];

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // ---------------- sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (opcode_t'(in_data.opcode))
            OP_ADD, OP_SUB, OP_NEG: state_next = S_DONE;
            OP_MUL: state_next = (a_ok && b_ok) ? S_MUL_GO : S_DONE;
            OP_POW: state_next = (a_ok && !in_data.wide_operand[WIDE_W-1]
                                  && in_data.wide_operand != '0) ? S_MUL_GO : S_DONE;
            OP_INV: state_next = a_ok ? S_INV_GO : S_DONE;
            OP_DIV: state_next = (a_ok && b_ok) ? S_INV_GO : S_DONE;
            OP_RED: state_next = S_RED;
            default: state_next = S_DONE;
          endcase
        end
      end
      S_MUL_GO: state_next = S_MUL_WAIT;
      S_MUL_WAIT: begin
        if (mul0_rsp.done) begin
          state_next = (op == OP_POW && n[WIDE_W-1:1] != '0) ? S_MUL_GO : S_DONE;
        end
      end
      S_INV_GO: state_next = S_INV_WAIT;
      S_INV_WAIT: begin
        if (euc_rsp.done) begin
          state_next = (op == OP_DIV && euc_rsp.ok) ? S_MUL_GO : S_DONE;
        end
      end
      S_RED:  if (rcnt == RCW'(1)) state_next = S_DONE;
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall      = (state != S_IDLE);
    mul_req.start = (state == S_MUL_GO);
    euc_req.start = (state == S_INV_GO);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          op   <= in_data.opcode;
          st   <= ST_OK;
          res  <= '0;
          ra   <= a_w;
          rb   <= b_w;
          n    <= in_data.wide_operand;
          neg  <= in_data.wide_operand[WIDE_W-1];
          rcnt <= RCW'(WIDE_W);
          case (opcode_t'(in_data.opcode))
            OP_ADD: if (!(a_ok && b_ok)) st <= ST_RANGE; else res <= add_r;
            OP_SUB: if (!(a_ok && b_ok)) st <= ST_RANGE; else res <= sub_r;
            OP_NEG: begin
              if (!a_ok) st <= ST_RANGE;
              else res <= (a_w == '0) ? '0 : modulus - a_w;
            end
            OP_MUL, OP_DIV: if (!(a_ok && b_ok)) st <= ST_RANGE;
            OP_POW: begin
              if (!a_ok) begin
                st <= ST_RANGE;
              end else if (in_data.wide_operand[WIDE_W-1]) begin
                st <= ST_NEGEXP;
              end else begin
                // r starts at 1 mod m; ra carries r, rb carries x
                ra  <= (modulus == W'(1)) ? '0 : W'(1);
                rb  <= a_w;
                res <= (modulus == W'(1)) ? '0 : W'(1);
              end
            end
            OP_INV: if (!a_ok) st <= ST_RANGE;
            OP_RED: begin
              ra <= '0;
              n  <= wabs;
            end
            default: ;
          endcase
        end
      end
      S_MUL_WAIT: begin
        if (mul0_rsp.done) begin
          if (op == OP_POW) begin
            if (n[0]) ra <= p0;
            rb  <= p1;
            n   <= n >> 1;
            res <= n[0] ? p0 : ra;
          end else begin
            res <= p0;
          end
        end
      end
      S_INV_WAIT: begin
        if (euc_rsp.done) begin
          if (!euc_rsp.ok) begin
            st <= ST_NOINV;
          end else if (op == OP_DIV) begin
            rb <= inv_v;
          end else begin
            res <= inv_v;
          end
        end
      end
      S_RED: begin
        ra   <= red_r;
        n    <= n << 1;
        rcnt <= rcnt - 1'b1;
        if (rcnt == RCW'(1)) begin
          res <= (neg && red_r != '0) ? modulus - red_r : red_r;
        end
      end
      default: ;
    endcase
  end

  // ---------------- output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_data.result <= (st == ST_OK) ? OPD_W'(res) : '0;
      out_data.status <= st;
    end
  end

endmodule

// File: hw/rtl/mau_mulmod.sv
// ----------------------------------------------------------------------------
// mau_mulmod
// Bit-serial modular multiplier: one bit of b per cycle, MSB first.
// ----------------------------------------------------------------------------
module mau_mulmod import mau_pkg::*; #(
  parameter int W = MOD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  unit_req_t    req,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic [W-1:0] m,
  output unit_rsp_t    rsp,
  output logic [W-1:0] p
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  acc;
  logic [W-1:0]  acc_next;
  logic [W-1:0]  bsh;
  logic [CW-1:0] cnt;
  logic          done;
  logic [W:0]    dbl;
  logic [W:0]    dbl_red;
  logic [W:0]    sum;

  always_comb begin
    dbl     = {acc, 1'b0};
    dbl_red = (dbl >= {1'b0, m}) ? dbl - {1'b0, m} : dbl;
    sum     = bsh[W-1] ? dbl_red + {1'b0, a} : dbl_red;
    acc_next = (sum >= {1'b0, m}) ? W'(sum - {1'b0, m}) : sum[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        cnt <= CW'(W);
      end else if (cnt != '0) begin
        cnt  <= cnt - 1'b1;
        done <= (cnt == CW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc <= '0;
      bsh <= b;
    end else if (cnt != '0) begin
      acc <= acc_next;
      bsh <= {bsh[W-2:0], 1'b0};
    end
  end

  assign rsp.done = done;
  assign rsp.ok   = 1'b1;
  assign p        = acc;

endmodule

// File: hw/rtl/mau_euclid.sv
// ----------------------------------------------------------------------------
// mau_euclid
// Extended Euclid inverse with a shift-subtract divider, one quotient bit
// per cycle; the Bezout coefficient is updated alongside each subtraction.
// ----------------------------------------------------------------------------
module mau_euclid import mau_pkg::*; #(
  parameter int W = MOD_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  unit_req_t    req,
  input  logic [W-1:0] a,
  input  logic [W-1:0] m,
  output unit_rsp_t    rsp,
  output logic [W-1:0] inv
);

  localparam int CW = $clog2(W + 1);
  localparam int KW = W + 2;
  localparam int TW = 2 * W - 1;
  localparam int MW = 2 * W + 1;

  euc_state_t state, state_next;

  logic [W-1:0]          s, t;
  logic signed [KW-1:0]  m0, m1;
  logic [TW-1:0]         ts;
  logic signed [MW-1:0]  ms;
  logic [CW-1:0]         k;
  logic                  done, ok;
  logic                  fit;
  logic signed [KW-1:0]  fix;

  assign fit = ts <= TW'(s);
  assign fix = m0 + $signed({2'b00, m});

  always_comb begin
    state_next = state;
    case (state)
      E_IDLE: if (req.start && a != '0) state_next = E_DIV;
      E_DIV:  if (k == CW'(1)) state_next = E_SWAP;
      E_SWAP: state_next = (s == '0) ? E_FIN : E_DIV;
      E_FIN:  state_next = E_IDLE;
      default: state_next = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      done  <= 1'b0;
      ok    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == E_IDLE && req.start && a == '0) begin
        done <= 1'b1;
        ok   <= (m == W'(1));
      end else if (state == E_FIN) begin
        done <= 1'b1;
        ok   <= (s == W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      E_IDLE: begin
        inv <= '0;
        s   <= m;
        t   <= a;
        m0  <= '0;
        m1  <= KW'(1);
        ts  <= {a, {(W-1){1'b0}}};
        ms  <= MW'(1) <<< (W - 1);
        k   <= CW'(W);
      end
      E_DIV: begin
        if (fit) begin
          s  <= s - ts[W-1:0];
          m0 <= m0 - ms[KW-1:0];
        end
        ts <= ts >> 1;
        ms <= ms >>> 1;
        k  <= k - 1'b1;
      end
      E_SWAP: begin
        // after the swap s holds the old divisor, t the remainder
        s  <= t;
        t  <= s;
        m0 <= m1;
        m1 <= m0;
        ts <= {s, {(W-1){1'b0}}};
        ms <= MW'(m0) <<< (W - 1);
        k  <= CW'(W);
      end
      E_FIN: begin
        inv <= m0[KW-1] ? fix[W-1:0] : m0[W-1:0];
      end
      default: ;
    endcase
  end

  assign rsp.done = done;
  assign rsp.ok   = ok;

endmodule
